FILE: src/rvde_pkg.sv
// ----------------------------------------------------------------------------
// RV32IM decode and execute package
// Shared widths, opcode and result codes, and the base ALU function.
// ----------------------------------------------------------------------------
`default_nettype none

package rvde_pkg;

  localparam int XLEN = 32;

  // Major opcodes.
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_MISC   = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_AMO    = 7'h2F;

  // funct7 codes.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes of the M extension.
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  // Exact system and fence words.
  localparam logic [31:0] INS_FENCE_I = 32'h0000_100F;
  localparam logic [31:0] INS_ECALL   = 32'h0000_0073;
  localparam logic [31:0] INS_EBREAK  = 32'h0010_0073;
  localparam logic [31:0] INS_MRET    = 32'h3020_0073;

  // Memory request kinds and sizes.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
  localparam logic [1:0] FAULT_SYSTEM  = 2'd2;

  // Per-instruction data that rides alongside the divider.
  typedef struct packed {
    logic [4:0]      rd;
    logic            wr;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] npc;
    logic [1:0]      kind;
    logic [1:0]      size;
    logic [XLEN-1:0] addr;
    logic [XLEN-1:0] sdata;
    logic            lsgn;
    logic [1:0]      fault;
    logic            is_md;
    logic [2:0]      f3;
    logic [2*XLEN-1:0] prod;
    logic            div0;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] a;
  } side_t;

  // Base integer ALU; alt selects sub or arithmetic right shift.
  function automatic logic [XLEN-1:0] alu(input logic [2:0] f3, input logic alt,
                                          input logic [XLEN-1:0] a,
                                          input logic [XLEN-1:0] b);
    logic [4:0] sh;
    logic [XLEN-1:0] res;
    sh = b[4:0];
    case (f3)
      3'd0: res = alt ? a - b : a + b;
      3'd1: res = a << sh;
      3'd2: res = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
      3'd3: res = {{(XLEN-1){1'b0}}, (a < b)};
      3'd4: res = a ^ b;
      3'd5: res = alt ? XLEN'($signed(a) >>> sh) : a >> sh;
      3'd6: res = a | b;
      default: res = a & b;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/rvde_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a side word and a
// valid bit carried through every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rvde_div #(
  parameter int SideW = 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     start,
  input  wire logic [rvde_pkg::XLEN-1:0] dividend,
  input  wire logic [rvde_pkg::XLEN-1:0] divisor,
  input  wire logic [SideW-1:0]         side_in,
  output logic                          done,
  output logic [rvde_pkg::XLEN-1:0]     quotient,
  output logic [rvde_pkg::XLEN-1:0]     remainder,
  output logic [SideW-1:0]              side_out
);

  localparam int N = rvde_pkg::XLEN;

  logic [N-1:0]     r_q   [1:N];
  logic [N-1:0]     q_q   [1:N];
  logic [N-1:0]     d_q   [1:N];
  logic [SideW-1:0] s_q   [1:N];
  logic [N:1]       v_q;

  logic [N-1:0]     src_r [0:N-1];
  logic [N-1:0]     src_q [0:N-1];
  logic [N-1:0]     src_d [0:N-1];
  logic [SideW-1:0] src_s [0:N-1];
  logic [N-1:0]     r_next [0:N-1];
  logic [N-1:0]     q_next [0:N-1];

  // One restoring step per stage.
  always_comb begin
    logic [N:0] trial;
    logic [N:0] diff;
    src_r[0] = '0;
    src_q[0] = dividend;
    src_d[0] = divisor;
    src_s[0] = side_in;
    for (int i = 1; i < N; i++) begin
      src_r[i] = r_q[i];
      src_q[i] = q_q[i];
      src_d[i] = d_q[i];
      src_s[i] = s_q[i];
    end
    for (int i = 0; i < N; i++) begin
      trial = {src_r[i], src_q[i][N-1]};
      diff  = trial - {1'b0, src_d[i]};
      if (!diff[N]) begin
        r_next[i] = diff[N-1:0];
        q_next[i] = {src_q[i][N-2:0], 1'b1};
      end else begin
        r_next[i] = trial[N-1:0];
        q_next[i] = {src_q[i][N-2:0], 1'b0};
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        r_q[i+1] <= r_next[i];
        q_q[i+1] <= q_next[i];
        d_q[i+1] <= src_d[i];
        s_q[i+1] <= src_s[i];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-1:1], start};
    end
  end

  assign done      = v_q[N];
  assign quotient  = q_q[N];
  assign remainder = r_q[N];
  assign side_out  = s_q[N];

endmodule

`default_nettype wire

FILE: src/rv32im_decode_execute_core.sv
// ----------------------------------------------------------------------------
// RV32IM decode and execute core
// Decodes one instruction and gives its register write, next pc, memory
// request and fault code.
// ----------------------------------------------------------------------------
// One instruction word is taken every cycle while the pipe is not held, and its
// result word is presented after it has passed the input register, then one
// decode/ALU/multiply stage, 32 divider stages (one quotient bit each) and one
// output register. All instructions take the same path so results leave in
// order. The whole pipe holds while a finished word waits at the output with
// out_stall high.
`default_nettype none

module rv32im_decode_execute_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] rs1_value,
  input  wire logic [31:0] rs2_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       dest_reg,
  output logic             dest_write,
  output logic [31:0]      dest_value,
  output logic [31:0]      next_pc,
  output logic [1:0]       mem_kind,
  output logic [1:0]       mem_size,
  output logic [31:0]      mem_address,
  output logic [31:0]      store_data,
  output logic             load_signed,
  output logic [1:0]       fault
);

  localparam int SIDE_W = $bits(rvde_pkg::side_t);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input register stage.
  logic        a_valid;
  logic [31:0] a_ins, a_pc, a_rs1, a_rs2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ins <= instruction;
      a_pc  <= pc;
      a_rs1 <= rs1_value;
      a_rs2 <= rs2_value;
    end
  end

  // Decode and execute everything except division.
  rvde_pkg::side_t ex;
  logic [31:0] div_a, div_b;

  always_comb begin
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi, imms, immb, immj, pc4;
    logic        take;
    logic        sa, sb;
    logic [65:0] prod;
    op   = a_ins[6:0];
    f3   = a_ins[14:12];
    f7   = a_ins[31:25];
    immi = {{20{a_ins[31]}}, a_ins[31:20]};
    imms = {{20{a_ins[31]}}, a_ins[31:25], a_ins[11:7]};
    immb = {{20{a_ins[31]}}, a_ins[7], a_ins[30:25], a_ins[11:8], 1'b0};
    immj = {{12{a_ins[31]}}, a_ins[19:12], a_ins[20], a_ins[30:21], 1'b0};
    pc4  = a_pc + 32'd4;
    take = 1'b0;

    ex       = '0;
    ex.rd    = a_ins[11:7];
    ex.npc   = pc4;
    ex.f3    = f3;
    ex.a     = a_rs1;

    unique case (op)
      rvde_pkg::OP_LUI: begin
        ex.val = {a_ins[31:12], 12'd0};
        ex.wr  = 1'b1;
      end
      rvde_pkg::OP_AUIPC: begin
        ex.val = a_pc + {a_ins[31:12], 12'd0};
        ex.wr  = 1'b1;
      end
      rvde_pkg::OP_JAL: begin
        ex.val = pc4;
        ex.wr  = 1'b1;
        ex.npc = a_pc + immj;
      end
      rvde_pkg::OP_JALR: begin
        if (f3 != 3'd0) begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end else begin
          ex.val = pc4;
          ex.wr  = 1'b1;
          ex.npc = (a_rs1 + immi) & ~32'd1;
        end
      end
      rvde_pkg::OP_BRANCH: begin
        case (f3)
          3'd0: take = a_rs1 == a_rs2;
          3'd1: take = a_rs1 != a_rs2;
          3'd4: take = $signed(a_rs1) < $signed(a_rs2);
          3'd5: take = !($signed(a_rs1) < $signed(a_rs2));
          3'd6: take = a_rs1 < a_rs2;
          3'd7: take = a_rs1 >= a_rs2;
          default: ex.fault = rvde_pkg::FAULT_ILLEGAL;
        endcase
        if (take) begin
          ex.npc = a_pc + immb;
        end
      end
      rvde_pkg::OP_LOAD: begin
        if (f3 == 3'd3 || f3 > 3'd5) begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end else begin
          ex.kind = rvde_pkg::MEM_LOAD;
          ex.size = f3[1:0];
          ex.lsgn = f3 < 3'd2;
          ex.addr = a_rs1 + immi;
        end
      end
      rvde_pkg::OP_STORE: begin
        if (f3 > 3'd2) begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end else begin
          ex.kind = rvde_pkg::MEM_STORE;
          ex.size = f3[1:0];
          ex.addr = a_rs1 + imms;
          if (f3[1:0] == rvde_pkg::SIZE_BYTE) begin
            ex.sdata = {24'd0, a_rs2[7:0]};
          end else if (f3[1:0] == rvde_pkg::SIZE_HALF) begin
            ex.sdata = {16'd0, a_rs2[15:0]};
          end else begin
            ex.sdata = a_rs2;
          end
        end
      end
      rvde_pkg::OP_IMM: begin
        if ((f3 == 3'd1 && f7 != rvde_pkg::F7_BASE) ||
            (f3 == 3'd5 && f7 != rvde_pkg::F7_BASE && f7 != rvde_pkg::F7_ALT)) begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end else begin
          ex.val = rvde_pkg::alu(f3, f3 == 3'd5 && f7 == rvde_pkg::F7_ALT, a_rs1, immi);
          ex.wr  = 1'b1;
        end
      end
      rvde_pkg::OP_REG: begin
        if (f7 == rvde_pkg::F7_MULDIV) begin
          ex.is_md = 1'b1;
          ex.wr    = 1'b1;
        end else if (f7 == rvde_pkg::F7_BASE) begin
          ex.val = rvde_pkg::alu(f3, 1'b0, a_rs1, a_rs2);
          ex.wr  = 1'b1;
        end else if (f7 == rvde_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
          ex.val = rvde_pkg::alu(f3, 1'b1, a_rs1, a_rs2);
          ex.wr  = 1'b1;
        end else begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end
      end
      rvde_pkg::OP_MISC: begin
        if (f3 != 3'd0 && a_ins != rvde_pkg::INS_FENCE_I) begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end
      end
      rvde_pkg::OP_SYSTEM: begin
        if (f3 != 3'd0 && f3 != 3'd4) begin
          ex.fault = rvde_pkg::FAULT_SYSTEM;
        end else if (a_ins == rvde_pkg::INS_ECALL || a_ins == rvde_pkg::INS_EBREAK ||
                     a_ins == rvde_pkg::INS_MRET) begin
          ex.fault = rvde_pkg::FAULT_SYSTEM;
        end else begin
          ex.fault = rvde_pkg::FAULT_ILLEGAL;
        end
      end
      rvde_pkg::OP_AMO: begin
        ex.fault = (f7[6:2] == 5'd1 && f3 == 3'd2) ? rvde_pkg::FAULT_SYSTEM
                                                   : rvde_pkg::FAULT_ILLEGAL;
      end
      default: ex.fault = rvde_pkg::FAULT_ILLEGAL;
    endcase

    // Multiply: 33-bit signed operands cover all four variants.
    sa      = a_rs1[31] && (f3 == rvde_pkg::F3_MULH || f3 == rvde_pkg::F3_MULHSU);
    sb      = a_rs2[31] && (f3 == rvde_pkg::F3_MULH);
    prod    = 66'($signed({sa, a_rs1}) * $signed({sb, a_rs2}));
    ex.prod = prod[63:0];

    // Divide operands as magnitudes, with sign fixups noted.
    ex.div0  = a_rs2 == 32'd0;
    ex.neg_r = a_rs1[31] && (f3 == rvde_pkg::F3_DIV || f3 == rvde_pkg::F3_REM);
    sb       = a_rs2[31] && (f3 == rvde_pkg::F3_DIV || f3 == rvde_pkg::F3_REM);
    ex.neg_q = ex.neg_r ^ sb;
    div_a    = ex.neg_r ? 32'd0 - a_rs1 : a_rs1;
    div_b    = sb ? 32'd0 - a_rs2 : a_rs2;

    // A fault cancels every effect; x0 is never written.
    if (ex.fault != rvde_pkg::FAULT_NONE) begin
      ex.wr    = 1'b0;
      ex.npc   = a_pc;
      ex.kind  = rvde_pkg::MEM_NONE;
      ex.size  = 2'd0;
      ex.addr  = '0;
      ex.sdata = '0;
      ex.lsgn  = 1'b0;
    end
    if (ex.rd == 5'd0) begin
      ex.wr = 1'b0;
    end
  end

  // Execute stage register.
  logic            b_valid;
  rvde_pkg::side_t b_side;
  logic [31:0]     b_div_a, b_div_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side  <= ex;
      b_div_a <= div_a;
      b_div_b <= div_b;
    end
  end

  // Divider pipe; every word passes through it.
  logic            d_valid;
  logic [31:0]     d_quo, d_rem;
  logic [SIDE_W-1:0] d_bits;
  rvde_pkg::side_t d_side;

  rvde_div #(
    .SideW(SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .start    (b_valid),
    .dividend (b_div_a),
    .divisor  (b_div_b),
    .side_in  (b_side),
    .done     (d_valid),
    .quotient (d_quo),
    .remainder(d_rem),
    .side_out (d_bits)
  );

  assign d_side = rvde_pkg::side_t'(d_bits);

  // Final result selection.
  logic [31:0] fin_val;

  always_comb begin
    fin_val = d_side.val;
    if (d_side.is_md) begin
      case (d_side.f3)
        rvde_pkg::F3_MUL: fin_val = d_side.prod[31:0];
        rvde_pkg::F3_MULH, rvde_pkg::F3_MULHSU, rvde_pkg::F3_MULHU:
          fin_val = d_side.prod[63:32];
        rvde_pkg::F3_DIV, rvde_pkg::F3_DIVU:
          fin_val = d_side.div0 ? 32'hFFFF_FFFF : (d_side.neg_q ? 32'd0 - d_quo : d_quo);
        default:
          fin_val = d_side.div0 ? d_side.a : (d_side.neg_r ? 32'd0 - d_rem : d_rem);
      endcase
    end
    if (!d_side.wr) begin
      fin_val = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dest_reg    <= d_side.rd;
      dest_write  <= d_side.wr;
      dest_value  <= fin_val;
      next_pc     <= d_side.npc;
      mem_kind    <= d_side.kind;
      mem_size    <= d_side.size;
      mem_address <= d_side.addr;
      store_data  <= d_side.sdata;
      load_signed <= d_side.lsgn;
      fault       <= d_side.fault;
    end
  end

`ifndef SYNTHESIS
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && dest_write |-> dest_reg != 5'd0)
    else $error("write to x0 escaped");
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault != rvde_pkg::FAULT_NONE |->
      !dest_write && mem_kind == rvde_pkg::MEM_NONE)
    else $error("faulting word has side effects");
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dest_write |-> dest_value == 32'd0)
    else $error("value not cleared without write");
  a_nomem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_kind == rvde_pkg::MEM_NONE |-> mem_address == 32'd0 && !load_signed)
    else $error("memory fields set without request");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_value) && $stable(next_pc))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
